### design/ikht_pkg.sv
// Shared types and constants for the ID-keyed handle table.
// Used by ikht_core and id_keyed_handle_table; depends on nothing.
package ikht_pkg;

  // Table geometry
  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PAYLOAD_BITS = 16;
  localparam int unsigned IDX_W        = 4;                  // key_index / out_index
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);  // occupancy count
  localparam int unsigned SUM_W        = CNT_W + 1;          // index plus small offset
  localparam int unsigned ID_W         = 32;
  localparam int unsigned CFG_W        = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        key_index;
    logic [ID_W-1:0]         key_id;
    logic [PAYLOAD_BITS-1:0] new_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        out_index;
    logic [ID_W-1:0]         out_id;
    logic [PAYLOAD_BITS-1:0] out_payload;
  } out_item_t;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

endpackage

### design/id_keyed_handle_table.sv
// ID-keyed handle table. An add answers without a slot read, a find or remove whose
// hint matches after one read; otherwise slots are read one per cycle from slot 0
// and a remove walks the later slots down one per cycle, all paced by the single read
// port of the slot memory. One item at a time: the next beat waits until the result
// has entered the output register and that register has room. Reset clears count
// and ID counter, sets max_entries to 16.
module id_keyed_handle_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ikht_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ikht_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ikht_pkg::CFG_W-1:0]     cfg_data_i
);
  import ikht_pkg::*;

  logic [CFG_W-1:0] max_entries_q;
  logic [CNT_W-1:0] limit;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             out_free;
  logic             res_valid;
  out_item_t        res;

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_entries_q <= cfg_data_i;
    end
  end

  // Clamp the capacity limit to the table depth
  assign limit = (CNT_W'(max_entries_q) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(max_entries_q);

  // Output register frees up when empty or when its beat is taken
  assign out_free = !out_valid_q || !out_stall_i;

  ikht_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .limit_i     (limit),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### design/ikht_core.sv
// Sequencer, slot memory and shared ID comparator of the handle table.
// Depends on ikht_pkg; instantiated by id_keyed_handle_table.
module ikht_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  ikht_pkg::in_item_t      in_item_i,
  input  logic [ikht_pkg::CNT_W-1:0] limit_i,
  input  logic                    out_free_i,
  output logic                    res_valid_o,
  output ikht_pkg::out_item_t     res_o
);
  import ikht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HINT  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [IDX_W-1:0]  at_q, at_d;
  logic              done_q, done_d;
  out_item_t         res_q, res_d;

  slot_t             slots_q [DEPTH];
  slot_t             rd_data_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  slot_t             mem_wd;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic              in_accept;
  logic              id_match;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  // Take a beat only when idle and the output register will have room
  assign in_stall_o  = !((state_q == S_IDLE) && !done_q && out_free_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign id_match    = (rd_data_q.id == id_q);
  assign res_valid_o = done_q;
  assign res_o       = res_q;

  // Sequencer: hint check, linear search, compaction walk
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    used_d    = used_q;
    next_id_d = next_id_q;
    scan_d    = scan_q;
    at_d      = at_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    hit       = 1'b0;
    hit_idx   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d  = in_item_i.op;
          id_d  = in_item_i.key_id;
          res_d = '0;
          case (in_item_i.op)
            OP_ADD: begin
              if (used_q >= limit_i) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_wa          = used_q[IDX_W-1:0];
                mem_wd.id       = next_id_q;
                mem_wd.payload  = in_item_i.new_payload;
                res_d.out_index = used_q[IDX_W-1:0];
                res_d.out_id    = next_id_q;
                next_id_d       = next_id_q + ID_W'(1);
                used_d          = used_q + CNT_W'(1);
              end
              done_d = 1'b1;
            end
            OP_REMOVE, OP_FIND: begin
              if (CNT_W'(in_item_i.key_index) < used_q) begin
                rd_en   = 1'b1;
                rd_addr = in_item_i.key_index;
                at_d    = in_item_i.key_index;
                state_d = S_HINT;
              end else if (used_q == '0) begin
                res_d.status = ST_MISSING;
                done_d       = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                scan_d  = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_HINT: begin
        if (id_match) begin
          hit     = 1'b1;
          hit_idx = at_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (id_match) begin
          hit     = 1'b1;
          hit_idx = scan_q;
        end else if (SUM_W'(scan_q) + SUM_W'(1) >= SUM_W'(used_q)) begin
          res_d        = '0;
          res_d.status = ST_MISSING;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + IDX_W'(1);
          scan_d  = scan_q + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // Move the slot just read down by one
        mem_we = 1'b1;
        mem_wa = scan_q;
        mem_wd = rd_data_q;
        if (SUM_W'(scan_q) + SUM_W'(2) < SUM_W'(used_q)) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(SUM_W'(scan_q) + SUM_W'(2));
          scan_d  = scan_q + IDX_W'(1);
        end else begin
          used_d          = used_q - CNT_W'(1);
          res_d           = '0;
          res_d.out_index = at_q;
          res_d.out_id    = id_q;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Matched slot: finish a find, or start compaction for a remove
    if (hit) begin
      res_d           = '0;
      res_d.out_index = hit_idx;
      res_d.out_id    = id_q;
      at_d            = hit_idx;
      if (op_q == OP_FIND) begin
        res_d.out_payload = rd_data_q.payload;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end else if (SUM_W'(hit_idx) + SUM_W'(1) < SUM_W'(used_q)) begin
        rd_en   = 1'b1;
        rd_addr = hit_idx + IDX_W'(1);
        scan_d  = hit_idx;
        state_d = S_SHIFT;
      end else begin
        used_d  = used_q - CNT_W'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      next_id_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    id_q   <= id_d;
    scan_q <= scan_d;
    at_q   <= at_d;
    res_q  <= res_d;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= slots_q[rd_addr];
    end
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for id_keyed_handle_table: a clocked driver and monitor around
// a cycle-free model of the table that predicts one result beat per accepted request.
// Depends on ikht_pkg for the beat types, op and status codes; reads no files.
`timescale 1ns / 1ps

module tb_top;
  import ikht_pkg::*;

  // Op 3 is not a real operation; the block answers it with status ok and zeros
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i = '0;

  // Table model state, updated as request beats are accepted
  logic [ID_W-1:0]         tbl_id [DEPTH];
  logic [PAYLOAD_BITS-1:0] tbl_pay [DEPTH];
  int unsigned             tbl_count = 0;
  logic [ID_W-1:0]         id_counter = '0;
  logic [CFG_W-1:0]        cap_limit = MAX_ENTRIES_RESET;

  in_item_t    queued_requests [$];
  out_item_t   pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  id_keyed_handle_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Apply one request to the table model and return the result it must produce
  function automatic out_item_t predict_outcome(input in_item_t req);
    out_item_t   res;
    int          hit;
    int unsigned lim;
    res = '0;
    res.status = ST_OK;
    case (req.op)
      OP_ADD: begin
        lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
        if (tbl_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          tbl_id[tbl_count] = id_counter;
          tbl_pay[tbl_count] = req.new_payload;
          res.out_index = IDX_W'(tbl_count);
          res.out_id = id_counter;
          id_counter = id_counter + 1;
          tbl_count++;
        end
      end
      OP_REMOVE, OP_FIND: begin
        // hinted slot first, then lowest matching slot
        hit = -1;
        if (req.key_index < tbl_count && tbl_id[req.key_index] == req.key_id) begin
          hit = req.key_index;
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_id[i] == req.key_id) hit = i;
          end
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.out_index = IDX_W'(hit);
          res.out_id = req.key_id;
          if (req.op == OP_FIND) begin
            res.out_payload = tbl_pay[hit];
          end else begin
            // close the gap
            for (int j = hit; j + 1 < tbl_count; j++) begin
              tbl_id[j] = tbl_id[j + 1];
              tbl_pay[j] = tbl_pay[j + 1];
            end
            tbl_count--;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_request(input logic [1:0] op, input int unsigned hint,
                                            input logic [ID_W-1:0] id,
                                            input logic [PAYLOAD_BITS-1:0] pay);
    in_item_t req;
    req.op = op;
    req.key_index = IDX_W'(hint);
    req.key_id = id;
    req.new_payload = pay;
    return req;
  endfunction

  // Draw a request against the current table; live IDs dominate lookups
  function automatic in_item_t random_request(input int unsigned add_pct);
    in_item_t    req;
    int unsigned roll;
    int unsigned slot;
    int unsigned pick;
    req.op = OP_ADD;
    req.key_index = IDX_W'($urandom_range(DEPTH - 1));
    req.key_id = $urandom;
    req.new_payload = PAYLOAD_BITS'($urandom);
    roll = $urandom_range(99);
    if (roll >= 95) begin
      req.op = OP_NONE;
    end else if (roll >= add_pct && tbl_count > 0) begin
      req.op = ($urandom_range(99) < 55) ? OP_FIND : OP_REMOVE;
      if ($urandom_range(99) < 8) begin
        // unknown ID: either random or the next one not yet handed out
        if ($urandom_range(1) == 1) req.key_id = id_counter;
      end else begin
        slot = $urandom_range(tbl_count - 1);
        req.key_id = tbl_id[slot];
        pick = $urandom_range(99);
        if (pick < 70) req.key_index = IDX_W'(slot);
        else if (pick < 85) req.key_index = IDX_W'($urandom_range(tbl_count - 1));
      end
    end
    return req;
  endfunction

  task automatic wait_drained();
    while (queued_requests.size() > 0 || in_valid_i || pending_results.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic send_one(input in_item_t req);
    queued_requests.push_back(req);
    wait_drained();
  endtask

  // Write max_entries while the block is idle
  task automatic write_cap(input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_limit = value;
  endtask

  // Request driver: predict on each accepted beat, then load the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) pending_results.push_back(predict_outcome(in_item_i));
      if (!in_valid_i || !in_stall_o) begin
        if (queued_requests.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
          in_valid_i <= 1'b1;
          in_item_i <= queued_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat: status=%0d index=%0d id=%h payload=%h",
                   $time, out_item_o.status, out_item_o.out_index, out_item_o.out_id,
                   out_item_o.out_payload);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_item_o !== want) begin
            $display("%0t: mismatch: expected status=%0d index=%0d id=%h payload=%h",
                     $time, want.status, want.out_index, want.out_id, want.out_payload);
            $display("%0t:           actual   status=%0d index=%0d id=%h payload=%h",
                     $time, out_item_o.status, out_item_o.out_index, out_item_o.out_id,
                     out_item_o.out_payload);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 10);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed requests, then random phases under different limits
  initial begin
    logic [CFG_W-1:0] caps [10];
    int unsigned      sent;
    int unsigned      burst;
    caps = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3, 5'd16, 5'd0, 5'd10, 5'd31};
    caps[7] = CFG_W'($urandom_range(31));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // lookups on an empty table and the unused op
    send_one(make_request(OP_FIND, 0, '0, '0));
    send_one(make_request(OP_REMOVE, 15, '1, '1));
    send_one(make_request(OP_NONE, 10, 32'hA5A5_A5A5, 16'h5A5A));
    // fill six slots with extreme and mixed payloads
    send_one(make_request(OP_ADD, 15, '1, 16'h0000));
    send_one(make_request(OP_ADD, 0, '0, 16'hFFFF));
    send_one(make_request(OP_ADD, 7, 32'h1234_5678, 16'h1234));
    send_one(make_request(OP_ADD, 8, 32'h8000_0001, 16'h8001));
    send_one(make_request(OP_ADD, 3, 32'h7FFF_FFFE, 16'h7FFE));
    send_one(make_request(OP_ADD, 12, 32'hDEAD_BEEF, 16'hAAAA));
    // finds: right hint, wrong hint, hint past the end, unknown ID
    send_one(make_request(OP_FIND, 0, tbl_id[0], 16'h0000));
    send_one(make_request(OP_FIND, 5, tbl_id[5], 16'hFFFF));
    send_one(make_request(OP_FIND, 1, tbl_id[3], 16'h0000));
    send_one(make_request(OP_FIND, 15, tbl_id[2], 16'h0000));
    send_one(make_request(OP_FIND, 2, '1, 16'h0000));
    // removes: hint past the end, first slot, middle slot with wrong hint, unknown ID
    send_one(make_request(OP_REMOVE, 9, tbl_id[5], 16'h0000));
    send_one(make_request(OP_REMOVE, 0, tbl_id[0], 16'h0000));
    send_one(make_request(OP_REMOVE, 0, tbl_id[2], 16'h0000));
    send_one(make_request(OP_REMOVE, 1, id_counter, 16'h0000));
    send_one(make_request(OP_FIND, 1, tbl_id[1], 16'h0000));

    // random phases: alternate fill-heavy and drain-heavy mixes
    foreach (caps[p]) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_cap(caps[p]);
      @(negedge clk_i);
      no_idle = (p == 6);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        repeat (burst) queued_requests.push_back(random_request((p % 2 == 0) ? 60 : 25));
        sent += burst;
        wait_drained();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
